// ===== rtl/assert_macros.svh =====
// assertion macros used by the correlation model core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fcstc_pkg.sv =====
// constants, register codes and exp table function of the correlation model core
`default_nettype none
package fcstc_pkg;

  localparam int EXP_TABLE_BITS_DEFAULT = 8;
  localparam int DARK_COMPONENTS = 2;
  localparam int EXP_SPAN_LOG2 = 4;
  localparam int X_BITS = 16 + EXP_SPAN_LOG2;
  localparam int SIDE_BITS_DEFAULT = 1;
  localparam int DIV_BITS_DEFAULT = 32;

  typedef enum logic [2:0] {
    REG_PARTICLE_NUMBER  = 3'd0,
    REG_TRIPLET_TIME     = 3'd1,
    REG_TRIPLET_FRACTION = 3'd2,
    REG_DARK_TIME        = 3'd3,
    REG_DARK_FRACTION    = 3'd4,
    REG_BASELINE         = 3'd5,
    REG_COUNT_RATE       = 3'd6,
    REG_BACKGROUND_RATE  = 3'd7
  } reg_index_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_DEN_ZERO = 2'd2;

  // exp(-m/256) in q52, taylor series of 25 terms
  function automatic logic [63:0] exp_part_q52(input logic [63:0] m);
    logic [63:0] term;
    logic signed [63:0] sum;
    term = 64'd1 << 52;
    sum = $signed(term);
    term = (term * m) / 64'd256;  sum = sum - $signed(term);
    term = (term * m) / 64'd512;  sum = sum + $signed(term);
    term = (term * m) / 64'd768;  sum = sum - $signed(term);
    term = (term * m) / 64'd1024; sum = sum + $signed(term);
    term = (term * m) / 64'd1280; sum = sum - $signed(term);
    term = (term * m) / 64'd1536; sum = sum + $signed(term);
    term = (term * m) / 64'd1792; sum = sum - $signed(term);
    term = (term * m) / 64'd2048; sum = sum + $signed(term);
    term = (term * m) / 64'd2304; sum = sum - $signed(term);
    term = (term * m) / 64'd2560; sum = sum + $signed(term);
    term = (term * m) / 64'd2816; sum = sum - $signed(term);
    term = (term * m) / 64'd3072; sum = sum + $signed(term);
    term = (term * m) / 64'd3328; sum = sum - $signed(term);
    term = (term * m) / 64'd3584; sum = sum + $signed(term);
    term = (term * m) / 64'd3840; sum = sum - $signed(term);
    term = (term * m) / 64'd4096; sum = sum + $signed(term);
    term = (term * m) / 64'd4352; sum = sum - $signed(term);
    term = (term * m) / 64'd4608; sum = sum + $signed(term);
    term = (term * m) / 64'd4864; sum = sum - $signed(term);
    term = (term * m) / 64'd5120; sum = sum + $signed(term);
    term = (term * m) / 64'd5376; sum = sum - $signed(term);
    term = (term * m) / 64'd5632; sum = sum + $signed(term);
    term = (term * m) / 64'd5888; sum = sum - $signed(term);
    term = (term * m) / 64'd6144; sum = sum + $signed(term);
    return sum < 0 ? 64'd0 : $unsigned(sum);
  endfunction

  // table entry k: exp(-k * 2^(4-bits)) in q30
  function automatic logic [30:0] exp_entry(input int k, input int bits);
    logic [63:0] u;
    logic [63:0] n;
    logic [63:0] val;
    logic [63:0] e1;
    logic [63:0] rounded;
    u = 64'(k) << (12 - bits);
    n = u >> 8;
    val = exp_part_q52(u & 64'd255);
    e1 = exp_part_q52(64'd256);
    for (int j = 0; j < 16; j++) begin
      if (64'(j) < n) begin
        val = ((val >> 21) * (e1 >> 21)) >> 10;
      end
    end
    rounded = val + (64'd1 << 21);
    return rounded[52:22];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fcstc_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module fcstc_div_pipe #(
  parameter int QUOT_BITS = fcstc_pkg::X_BITS,
  parameter int DIV_BITS  = fcstc_pkg::DIV_BITS_DEFAULT,
  parameter int SIDE_BITS = fcstc_pkg::SIDE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [DIV_BITS-1:0]  in_rem,
  input  logic [QUOT_BITS-1:0] in_low,
  input  logic [DIV_BITS-1:0]  divisor,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_valid,
  output logic [QUOT_BITS-1:0] out_quot,
  output logic [SIDE_BITS-1:0] out_side
);

  logic                 stage_valid [QUOT_BITS];
  logic [DIV_BITS-1:0]  stage_rem   [QUOT_BITS];
  logic [QUOT_BITS-1:0] stage_lq    [QUOT_BITS];
  logic [SIDE_BITS-1:0] stage_side  [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic                 src_valid;
    logic [DIV_BITS-1:0]  src_rem;
    logic [QUOT_BITS-1:0] src_lq;
    logic [SIDE_BITS-1:0] src_side;
    logic [DIV_BITS:0]    shifted;
    logic                 ge;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_rem;
      assign src_lq    = in_low;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_valid = stage_valid[k-1];
      assign src_rem   = stage_rem[k-1];
      assign src_lq    = stage_lq[k-1];
      assign src_side  = stage_side[k-1];
    end

    assign shifted = {src_rem, src_lq[QUOT_BITS-1]};
    assign ge = shifted >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (adv) begin
        stage_valid[k] <= src_valid;
        stage_rem[k] <= ge ? DIV_BITS'(shifted - {1'b0, divisor}) : shifted[DIV_BITS-1:0];
        stage_lq[k] <= {src_lq[QUOT_BITS-2:0], ge};
        stage_side[k] <= src_side;
      end
    end
  end

  assign out_valid = stage_valid[QUOT_BITS-1];
  assign out_quot  = stage_lq[QUOT_BITS-1];
  assign out_side  = stage_side[QUOT_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/fcs_triplet_correlation_model_core.sv =====
// top level: fcs correlation model with two dark-state exponentials
// one request per cycle sustained while lag_stall is low; stages from request to result
// (input register, two 20-stage exp dividers, 5 stages interpolation and sum,
// 47-stage fraction divider, 4 multiply stages, 33-stage particle divider, output)
// a write of any register holds lag_stall high while the 62-step iterative count-rate
// ratio divider loads and runs; reset loads register defaults at once
`default_nettype none
`include "assert_macros.svh"
module fcs_triplet_correlation_model_core #(
  parameter int EXP_TABLE_BITS = fcstc_pkg::EXP_TABLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               lag_valid,
  output logic               lag_stall,
  input  logic [47:0]        lag_time,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] correlation,
  output logic [1:0]         status,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [31:0]        write_data
);

  localparam int X_BITS    = fcstc_pkg::X_BITS;
  localparam int FB        = X_BITS - EXP_TABLE_BITS;
  localparam int TABLE_LEN = (1 << EXP_TABLE_BITS) + 1;
  localparam int R_BITS    = 62;
  localparam logic [5:0] CAL_STEPS = 6'd62;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;

  // configuration registers
  logic [31:0] particle_number, triplet_time, dark_time, baseline;
  logic [31:0] photon_rate, background_rate;
  logic [15:0] triplet_fraction, dark_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_number  <= 32'd40960;
      triplet_time     <= 32'd12288;
      triplet_fraction <= 16'd13107;
      dark_time        <= 32'd1228800;
      dark_fraction    <= 16'd0;
      baseline         <= 32'd0;
      photon_rate      <= 32'd0;
      background_rate  <= 32'd0;
    end else if (write_enable) begin
      case (fcstc_pkg::reg_index_t'(write_index))
        fcstc_pkg::REG_PARTICLE_NUMBER:  particle_number  <= write_data;
        fcstc_pkg::REG_TRIPLET_TIME:     triplet_time     <= write_data;
        fcstc_pkg::REG_TRIPLET_FRACTION: triplet_fraction <= write_data[15:0];
        fcstc_pkg::REG_DARK_TIME:        dark_time        <= write_data;
        fcstc_pkg::REG_DARK_FRACTION:    dark_fraction    <= write_data[15:0];
        fcstc_pkg::REG_BASELINE:         baseline         <= write_data;
        fcstc_pkg::REG_COUNT_RATE:       photon_rate      <= write_data;
        fcstc_pkg::REG_BACKGROUND_RATE:  background_rate  <= write_data;
        default: begin
        end
      endcase
    end
  end

  // derived configuration values
  logic [15:0] comp_th  [2];
  logic [31:0] comp_tau [2];
  logic signed [17:0] den;
  logic den_zero, den_neg;
  logic [16:0] den_mag;
  logic [31:0] n_eff;
  logic [55:0] n_div;
  logic [31:0] rate_diff;

  assign comp_th[0]  = (fcstc_pkg::DARK_COMPONENTS >= 1) ? triplet_fraction : 16'd0;
  assign comp_th[1]  = (fcstc_pkg::DARK_COMPONENTS >= 2) ? dark_fraction : 16'd0;
  assign comp_tau[0] = triplet_time;
  assign comp_tau[1] = dark_time;
  assign den = 18'sd65536 - $signed({2'b0, comp_th[0]}) - $signed({2'b0, comp_th[1]});
  assign den_zero = den == 18'sd0;
  assign den_neg = den[17];
  assign den_mag = den_neg ? 17'(-den) : den[16:0];
  assign n_eff = (particle_number == 32'd0) ? 32'd1 : particle_number;
  assign n_div = {n_eff, 24'd0};
  assign rate_diff = (photon_rate >= background_rate) ? photon_rate - background_rate
                                                      : background_rate - photon_rate;

  // iterative ratio divider: floor(|cr-bg| * 2^30 / cr)
  logic load_req, busy, cal_busy;
  logic [5:0] cal_cnt;
  logic [31:0] cal_rem;
  logic [R_BITS-1:0] cal_lq, rate_ratio;
  logic [32:0] cal_sh;
  logic cal_ge;
  logic [R_BITS-1:0] cal_lq_next;

  assign cal_sh = {cal_rem, cal_lq[R_BITS-1]};
  assign cal_ge = cal_sh >= {1'b0, photon_rate};
  assign cal_lq_next = {cal_lq[R_BITS-2:0], cal_ge};
  assign cal_busy = load_req | busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_req   <= 1'b0;
      busy       <= 1'b0;
      cal_cnt    <= 6'd0;
      rate_ratio <= R_BITS'(ONE_Q30);
    end else begin
      load_req <= write_enable;
      if (load_req) begin
        busy    <= 1'b1;
        cal_cnt <= CAL_STEPS;
        cal_rem <= 32'd0;
        cal_lq  <= {rate_diff, 30'd0};
      end else if (busy) begin
        cal_rem <= cal_ge ? 32'(cal_sh - {1'b0, photon_rate}) : cal_sh[31:0];
        cal_lq  <= cal_lq_next;
        cal_cnt <= cal_cnt - 6'd1;
        if (cal_cnt == 6'd1) begin
          busy <= 1'b0;
          rate_ratio <= (photon_rate == 32'd0) ? R_BITS'(ONE_Q30) : cal_lq_next;
        end
      end
    end
  end

  // pipeline control
  logic adv;
  assign adv = !result_valid || !result_stall;
  assign lag_stall = !adv || cal_busy;

  // exp table
  logic [30:0] exp_rom [TABLE_LEN];
  for (genvar k = 0; k < TABLE_LEN; k++) begin : g_rom
    assign exp_rom[k] = fcstc_pkg::exp_entry(k, EXP_TABLE_BITS);
  end

  // input register
  logic s0_valid;
  logic [47:0] s0_time;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= lag_valid && !lag_stall;
      s0_time  <= lag_time;
    end
  end

  // per component: x = t / tau, interpolation, penalty th * (1 - e)
  logic              x_valid [2];
  logic [X_BITS-1:0] x_quot  [2];
  logic              x_zero  [2];
  logic [30:0]       a_lo [2], a_hi [2];
  logic [FB-1:0]     a_frac [2];
  logic              a_zero [2];
  logic [30+FB:0]    b_prod [2];
  logic [30:0]       b_lo [2];
  logic              b_down [2], b_zero [2];
  logic [30:0]       c_exp [2];
  logic [46:0]       d_pen [2];
  logic a_valid, b_valid, c_valid, d_valid;

  for (genvar c = 0; c < 2; c++) begin : g_comp
    logic zero_in;
    logic [EXP_TABLE_BITS:0] idx_lo, idx_hi;
    logic [30:0] step;

    assign zero_in = (comp_tau[c] == 32'd0) || (s0_time >= {8'd0, comp_tau[c], 8'd0});

    fcstc_div_pipe #(
      .QUOT_BITS(X_BITS),
      .DIV_BITS (32),
      .SIDE_BITS(1)
    ) u_xdiv (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (s0_valid),
      .in_rem   (s0_time[39:8]),
      .in_low   ({s0_time[7:0], 12'd0}),
      .divisor  (comp_tau[c]),
      .in_side  (zero_in),
      .out_valid(x_valid[c]),
      .out_quot (x_quot[c]),
      .out_side (x_zero[c])
    );

    assign idx_lo = {1'b0, x_quot[c][X_BITS-1 -: EXP_TABLE_BITS]};
    assign idx_hi = idx_lo + 1'b1;
    assign step = 31'(b_prod[c] >> FB);

    always_ff @(posedge clk) begin
      if (adv) begin
        a_lo[c]   <= exp_rom[idx_lo];
        a_hi[c]   <= exp_rom[idx_hi];
        a_frac[c] <= x_quot[c][FB-1:0];
        a_zero[c] <= x_zero[c];
        b_lo[c]   <= a_lo[c];
        b_down[c] <= a_lo[c] >= a_hi[c];
        b_zero[c] <= a_zero[c];
        b_prod[c] <= (31+FB)'((a_lo[c] >= a_hi[c]) ? a_lo[c] - a_hi[c] : a_hi[c] - a_lo[c])
                     * (31+FB)'(a_frac[c]);
        c_exp[c]  <= b_zero[c] ? 31'd0 : (b_down[c] ? b_lo[c] - step : b_lo[c] + step);
        d_pen[c]  <= 47'(comp_th[c]) * 47'(ONE_Q30 - c_exp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= x_valid[0] && x_valid[1];
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // numerator
  logic e_valid;
  logic signed [48:0] e_num;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
      e_num   <= (49'sd1 <<< 46) - $signed({2'b0, d_pen[0]}) - $signed({2'b0, d_pen[1]});
    end
  end

  // pre = num / den, sign and magnitude
  logic [46:0] num_mag;
  logic q_valid, q_neg;
  logic [46:0] q_pre;
  assign num_mag = e_num[48] ? 47'(-e_num) : e_num[46:0];

  fcstc_div_pipe #(
    .QUOT_BITS(47),
    .DIV_BITS (17),
    .SIDE_BITS(1)
  ) u_prediv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (e_valid),
    .in_rem   (17'd0),
    .in_low   (num_mag),
    .divisor  (den_mag),
    .in_side  (e_num[48] ^ den_neg),
    .out_valid(q_valid),
    .out_quot (q_pre),
    .out_side (q_neg)
  );

  // |pre| * r * r in partial products
  logic m1_valid, m1_neg;
  logic [63:0] m1_p00;
  logic [61:0] m1_p01;
  logic [46:0] m1_p10;
  logic [44:0] m1_p11;
  logic m2_valid, m2_neg;
  logic [108:0] m2_prod;
  logic m3_valid, m3_neg, m3_big;
  logic [63:0] m3_p00;
  logic [61:0] m3_p01;
  logic [62:0] m3_p10;
  logic [60:0] m3_p11;
  logic m4_valid, m4_neg, m4_big;
  logic [124:0] m4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= q_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_neg  <= q_neg;
      m1_p00  <= 64'(q_pre[31:0]) * 64'(rate_ratio[31:0]);
      m1_p01  <= 62'(q_pre[31:0]) * 62'(rate_ratio[61:32]);
      m1_p10  <= 47'(q_pre[46:32]) * 47'(rate_ratio[31:0]);
      m1_p11  <= 45'(q_pre[46:32]) * 45'(rate_ratio[61:32]);
      m2_neg  <= m1_neg;
      m2_prod <= 109'(m1_p00) + (109'(m1_p01) << 32) + (109'(m1_p10) << 32)
                 + (109'(m1_p11) << 64);
      m3_neg  <= m2_neg;
      m3_big  <= |m2_prod[108:93];
      m3_p00  <= 64'(m2_prod[61:30]) * 64'(rate_ratio[31:0]);
      m3_p01  <= 62'(m2_prod[61:30]) * 62'(rate_ratio[61:32]);
      m3_p10  <= 63'(m2_prod[92:62]) * 63'(rate_ratio[31:0]);
      m3_p11  <= 61'(m2_prod[92:62]) * 61'(rate_ratio[61:32]);
      m4_neg  <= m3_neg;
      m4_big  <= m3_big;
      m4_sum  <= 125'(m3_p00) + (125'(m3_p01) << 32) + (125'(m3_p10) << 32)
                 + (125'(m3_p11) << 64);
    end
  end

  // term = v * r / (n * 2^24), big when it cannot fit 33 bits
  logic t_valid;
  logic [32:0] t_term;
  logic [1:0] t_side;
  logic quot_over;
  assign quot_over = m4_sum[124:33] >= 92'(n_div);

  fcstc_div_pipe #(
    .QUOT_BITS(33),
    .DIV_BITS (56),
    .SIDE_BITS(2)
  ) u_termdiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (m4_valid),
    .in_rem   (m4_sum[88:33]),
    .in_low   (m4_sum[32:0]),
    .divisor  (n_div),
    .in_side  ({m4_neg, m4_big | quot_over}),
    .out_valid(t_valid),
    .out_quot (t_term),
    .out_side (t_side)
  );

  // baseline add, clip, output register
  logic signed [31:0] base24;
  logic signed [34:0] g_sum;
  logic g_over;
  assign base24 = $signed(baseline) >>> 4;
  assign g_sum = t_side[1] ? {{3{base24[31]}}, base24} - $signed({2'b0, t_term})
                           : {{3{base24[31]}}, base24} + $signed({2'b0, t_term});
  assign g_over = (g_sum[34:31] != 4'b0000) && (g_sum[34:31] != 4'b1111);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= t_valid;
      if (den_zero) begin
        correlation <= 32'sd0;
        status      <= fcstc_pkg::STATUS_DEN_ZERO;
      end else if (t_side[0] || g_over) begin
        correlation <= (t_side[0] ? t_side[1] : g_sum[34]) ? 32'sh80000000 : 32'sh7fffffff;
        status      <= fcstc_pkg::STATUS_SAT;
      end else begin
        correlation <= g_sum[31:0];
        status      <= fcstc_pkg::STATUS_OK;
      end
    end
  end

  `ASSERT_IMPLY(a_cal_stall, clk, rst, cal_busy, lag_stall)
  `ASSERT_NEXT(a_cal_start, clk, rst, load_req, busy)
  `ASSERT_IMPLY(a_den_zero, clk, rst, result_valid && den_zero, status == fcstc_pkg::STATUS_DEN_ZERO && correlation == 32'sd0)
  `ASSERT_IMPLY(a_sat_rail, clk, rst, result_valid && status == fcstc_pkg::STATUS_SAT, correlation == 32'sh7fffffff || correlation == 32'sh80000000)

endmodule
`default_nettype wire
